/* sv/pipw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pipw_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = 16;
    localparam int DELTA_W   = 3;
    localparam int QDIFF_W   = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_X = 2'd0,
        REG_POINT_Y = 2'd1
    } t_cfg_reg;

    typedef logic [2:0] t_quad;

    localparam t_quad QUAD_1 = 3'd1;
    localparam t_quad QUAD_2 = 3'd2;
    localparam t_quad QUAD_3 = 3'd3;
    localparam t_quad QUAD_4 = 3'd4;

    localparam logic signed [QDIFF_W-1:0] QD_POS3 = 4'sd3;
    localparam logic signed [QDIFF_W-1:0] QD_NEG3 = -4'sd3;
    localparam logic signed [QDIFF_W-1:0] QD_POS2 = 4'sd2;
    localparam logic signed [QDIFF_W-1:0] QD_NEG2 = -4'sd2;

    localparam logic signed [SUM_W-1:0] SUM_POS4 = 16'sd4;
    localparam logic signed [SUM_W-1:0] SUM_NEG4 = -16'sd4;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_pt;

    function automatic t_quad quadrant(input t_pt v, input t_pt p);
        logic x_lt;
        logic y_lt;
        x_lt = $signed(v.x) < $signed(p.x);
        y_lt = $signed(v.y) < $signed(p.y);
        if (x_lt) begin
            return y_lt ? QUAD_1 : QUAD_4;
        end
        return y_lt ? QUAD_2 : QUAD_3;
    endfunction

endpackage

`default_nettype wire

/* sv/pipw_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pipw_vtx_if import pipw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] vertex_x;
    logic [COORD_W-1:0] vertex_y;
    logic               last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pipw_res_if import pipw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [SUM_W-1:0] winding_sum;

    modport source (output valid, output inside_res, output winding_sum, input ready);
    modport sink (input valid, input inside_res, input winding_sum, output ready);
endinterface

interface pipw_cfg_if import pipw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/pipw_edge.sv */
`timescale 1ns / 1ps
`default_nettype none

module pipw_edge import pipw_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire t_pt                   i_from,
    input  wire t_pt                   i_to,
    input  wire t_pt                   i_point,
    output logic signed [DELTA_W-1:0]  o_delta
);

    logic signed [DIFF_W-1:0]  ux, uy, wx, wy;
    logic signed [QDIFF_W-1:0] n_qd;
    logic signed [PROD_W-1:0]  n_p1, n_p2;
    logic signed [PROD_W-1:0]  r_p1, r_p2;
    logic signed [QDIFF_W-1:0] r_qd;
    logic                      r_wy_neg;
    logic                      left;

    always_comb begin
        ux   = $signed({i_from.x[COORD_W-1], i_from.x}) - $signed({i_point.x[COORD_W-1], i_point.x});
        uy   = $signed({i_from.y[COORD_W-1], i_from.y}) - $signed({i_point.y[COORD_W-1], i_point.y});
        wx   = $signed({i_to.x[COORD_W-1], i_to.x}) - $signed({i_point.x[COORD_W-1], i_point.x});
        wy   = $signed({i_to.y[COORD_W-1], i_to.y}) - $signed({i_point.y[COORD_W-1], i_point.y});
        n_qd = $signed({1'b0, quadrant(i_to, i_point)}) - $signed({1'b0, quadrant(i_from, i_point)});
        n_p1 = PROD_W'(wx) * PROD_W'(uy);
        n_p2 = PROD_W'(wy) * PROD_W'(ux);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_qd     <= n_qd;
            r_wy_neg <= wy[DIFF_W-1];
        end
    end

    always_comb begin
        left = r_wy_neg ? (r_p1 < r_p2) : (r_p1 > r_p2);
        case (r_qd)
            QD_POS3: o_delta = -3'sd1;
            QD_NEG3: o_delta = 3'sd1;
            QD_POS2: o_delta = left ? -3'sd2 : 3'sd2;
            QD_NEG2: o_delta = left ? 3'sd2 : -3'sd2;
            default: o_delta = DELTA_W'(r_qd);
        endcase
    end

endmodule

`default_nettype wire

/* sv/point_in_polygon_winding_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Quadrant winding-number point-in-polygon test. Write the query point through
// the configuration channel, then stream the polygon one vertex per transaction
// with last_vertex set on the final one; that transaction yields one result with
// the quadrant sum (four times the winding number) and inside_res set when the
// sum is plus or minus four. One vertex is taken every cycle while no result
// waits to be taken; a result passes through the input register, the product
// register of the edge cross-multiply and the result register. The pipeline
// stalls only while a result waits to be taken.

module point_in_polygon_winding_core import pipw_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    pipw_cfg_if.sink i_cfg,
    pipw_vtx_if.sink i_vtx,
    pipw_res_if.source o_res
);

    logic                      advance;
    logic                      accept;
    t_pt                       vtx;
    logic signed [DELTA_W-1:0] d_edge, d_close;
    logic signed [SUM_W-1:0]   n_sum;

    t_pt                     r_point;
    t_pt                     r_prev, r_first;
    logic                    r_have_first;
    logic                    r_a_valid, r_a_has_prev, r_a_last;
    t_pt                     r_a_cur, r_a_prev, r_a_first;
    logic                    r_b_valid, r_b_has_prev, r_b_last;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_out_valid;
    logic                    r_out_inside;
    logic [SUM_W-1:0]        r_out_sum;

    assign advance     = !r_out_valid || o_res.ready;
    assign accept      = i_vtx.valid && advance;
    assign vtx         = '{x: i_vtx.vertex_x, y: i_vtx.vertex_y};
    assign i_vtx.ready = advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POINT_X: r_point.x <= i_cfg.data;
                REG_POINT_Y: r_point.y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_prev       <= '0;
            r_first      <= '0;
        end else if (accept) begin
            r_prev <= vtx;
            if (!r_have_first) begin
                r_first <= vtx;
            end
            r_have_first <= !i_vtx.last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_cur      <= vtx;
            r_a_prev     <= r_prev;
            r_a_first    <= r_have_first ? r_first : vtx;
            r_a_has_prev <= r_have_first;
            r_a_last     <= i_vtx.last_vertex;
            r_b_has_prev <= r_a_has_prev;
            r_b_last     <= r_a_last;
        end
    end

    pipw_edge u_edge (
        .i_clk   (i_clk),
        .i_en    (advance),
        .i_from  (r_a_prev),
        .i_to    (r_a_cur),
        .i_point (r_point),
        .o_delta (d_edge)
    );

    pipw_edge u_close (
        .i_clk   (i_clk),
        .i_en    (advance),
        .i_from  (r_a_cur),
        .i_to    (r_a_first),
        .i_point (r_point),
        .o_delta (d_close)
    );

    always_comb begin
        n_sum = r_b_has_prev ? r_sum + SUM_W'(d_edge) : '0;
        if (r_b_last) begin
            n_sum = n_sum + SUM_W'(d_close);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else if (advance) begin
            r_a_valid   <= i_vtx.valid;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid && r_b_last;
            if (r_b_valid) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sum    <= n_sum;
            r_out_inside <= (n_sum == SUM_POS4) || (n_sum == SUM_NEG4);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.inside_res  = r_out_inside;
    assign o_res.winding_sum = r_out_sum;

endmodule

`default_nettype wire
